/* sv/pclm_pkg.sv */
package pclm_pkg;

  typedef enum logic [3:0] {
    CMD_CREATE     = 4'd0,
    CMD_COUNT      = 4'd1,
    CMD_FIRST      = 4'd2,
    CMD_LAST       = 4'd3,
    CMD_NEXT       = 4'd4,
    CMD_PREV       = 4'd5,
    CMD_CURR       = 4'd6,
    CMD_INS_AFTER  = 4'd7,
    CMD_INS_BEFORE = 4'd8,
    CMD_APPEND     = 4'd9,
    CMD_PREPEND    = 4'd10,
    CMD_REMOVE     = 4'd11,
    CMD_TRIM       = 4'd12,
    CMD_CONCAT     = 4'd13,
    CMD_FREE       = 4'd14
  } cmd_t;

  typedef enum logic [1:0] {
    CUR_NONE   = 2'd0,
    CUR_NODE   = 2'd1,
    CUR_BEFORE = 2'd2,
    CUR_AFTER  = 2'd3
  } cur_mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_NOITEM  = 2'd2
  } status_t;

endpackage

/* sv/pclm_ram.sv */
module pclm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/pooled_cursor_list_manager.sv */
// Channel   Ports                                      Transaction
// command   start, busy, in_cmd, in_list_sel,          start high, busy low
//           in_second_list, in_item_value
// result    out_valid, out_status, out_item_out,       out_valid high, one cycle
//           out_new_list, out_count_out
// A command runs from S_HEAD through its access states to S_DONE; free visits each node in turn.
// Node storage is three simple dual-port RAMs with registered reads, so each link
// read is registered before use and writes to one RAM are spread over successive states.
// Reset is synchronous, active low, and clears list sizes, cursor modes and pools.
// Busy stays high until the result strobe; the receiver cannot stall.
module pooled_cursor_list_manager
  import pclm_pkg::*;
#(
  parameter int NODE_COUNT = 128,
  parameter int HEAD_COUNT = 16,
  parameter int ITEM_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_cmd,
  input  logic [3:0]  in_list_sel,
  input  logic [3:0]  in_second_list,
  input  logic [31:0] in_item_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_item_out,
  output logic [3:0]  out_new_list,
  output logic [7:0]  out_count_out
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int SW = $clog2(NODE_COUNT + 1);
  localparam int HW = HEAD_COUNT > 1 ? $clog2(HEAD_COUNT) : 1;
  localparam int CW = $clog2(HEAD_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_ITEM, S_STEP, S_ALLOC, S_LINK, S_LINK2, S_LINK3,
    S_UNL, S_REL, S_CAT, S_FREE_RD, S_FREE_WR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cmd_r, cmd_nxt, h_r, h_nxt, h2_r, h2_nxt;
  logic [ITEM_BITS-1:0] item_r, item_nxt, io_r, io_nxt;
  logic [NW-1:0] hh_r, hh_nxt, ht_r, ht_nxt, hc_r, hc_nxt;
  logic [SW-1:0] hs_r, hs_nxt;
  logic [1:0] hm_r, hm_nxt, st_r, st_nxt;
  logic wb_r, wb_nxt, after_r, after_nxt;
  logic [HW-1:0] widx_r, widx_nxt;
  logic [3:0] newl_r, newl_nxt;
  logic [NW-1:0] n_r, n_nxt, a_r, a_nxt, x_r, x_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic [NW-1:0] ftop_r, ftop_nxt;
  logic [SW-1:0] fcnt_r, fcnt_nxt, fresh_n_r, fresh_n_nxt;
  logic [CW-1:0] fresh_h_r, fresh_h_nxt, fhc_r, fhc_nxt;
  logic [HW-1:0] fhs_r [HEAD_COUNT];
  logic [NW-1:0] lh_r [HEAD_COUNT];
  logic [NW-1:0] lt_r [HEAD_COUNT];
  logic [NW-1:0] lc_r [HEAD_COUNT];
  logic [SW-1:0] ls_r [HEAD_COUNT];
  logic [1:0]    lm_r [HEAD_COUNT];
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [31:0] out_item_r, out_item_nxt;
  logic [3:0] out_new_r, out_new_nxt;
  logic [7:0] out_cnt_r, out_cnt_nxt;

  logic fh_push;
  logic [HW-1:0] fh_push_val;
  logic hw_en;
  logic [HW-1:0] hw_idx;
  logic [NW-1:0] hw_h, hw_t, hw_c;
  logic [SW-1:0] hw_s;
  logic [1:0] hw_m;

  logic im_we, nx_we, pv_we;
  logic [NW-1:0] im_wa, im_ra, nx_wa, nx_ra, pv_wa, pv_ra, nx_wd, pv_wd, nx_rd, pv_rd;
  logic [ITEM_BITS-1:0] im_wd, im_rd;

  pclm_ram #(.WIDTH(ITEM_BITS), .DEPTH(NODE_COUNT)) u_item (
    .clk(clk), .we(im_we), .waddr(im_wa), .wdata(im_wd), .raddr(im_ra), .rdata(im_rd));
  pclm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  pclm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_item_out  = out_item_r;
  assign out_new_list  = out_new_r;
  assign out_count_out = out_cnt_r;

  always_comb begin
    logic [HW-1:0] hi, h2i;
    logic [NW-1:0] eh, et, ec, bh, bt, bc, xv;
    logic [SW-1:0] es, bs;
    logic [1:0] em, bm;
    logic [3:0] where;
    hi  = HW'(h_r);
    h2i = HW'(h2_r);
    eh = lh_r[hi];
    et = lt_r[hi];
    ec = lc_r[hi];
    es = ls_r[hi];
    em = lm_r[hi];
    bh = lh_r[h2i];
    bt = lt_r[h2i];
    bc = lc_r[h2i];
    bs = ls_r[h2i];
    bm = lm_r[h2i];
    where = cmd_r - CMD_INS_AFTER;
    xv = '0;

    state_nxt = state_r;
    cmd_nxt = cmd_r; h_nxt = h_r; h2_nxt = h2_r; item_nxt = item_r; io_nxt = io_r;
    hh_nxt = hh_r; ht_nxt = ht_r; hc_nxt = hc_r; hs_nxt = hs_r; hm_nxt = hm_r;
    st_nxt = st_r; wb_nxt = wb_r; after_nxt = after_r; widx_nxt = widx_r;
    newl_nxt = newl_r; n_nxt = n_r; a_nxt = a_r; x_nxt = x_r; k_nxt = k_r;
    ftop_nxt = ftop_r; fcnt_nxt = fcnt_r; fresh_n_nxt = fresh_n_r;
    fresh_h_nxt = fresh_h_r; fhc_nxt = fhc_r;
    fh_push = 1'b0; fh_push_val = h2i;
    hw_en = 1'b0; hw_idx = widx_r;
    hw_h = hh_r; hw_t = ht_r; hw_c = hc_r; hw_s = hs_r; hw_m = hm_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r; out_item_nxt = out_item_r;
    out_new_nxt = out_new_r; out_cnt_nxt = out_cnt_r;
    im_we = 1'b0; im_wa = n_r; im_wd = item_r; im_ra = hc_r;
    nx_we = 1'b0; nx_wa = n_r; nx_wd = '0; nx_ra = n_r;
    pv_we = 1'b0; pv_wa = n_r; pv_wd = '0; pv_ra = n_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd; h_nxt = in_list_sel; h2_nxt = in_second_list;
          item_nxt = ITEM_BITS'(in_item_value);
          io_nxt = '0; newl_nxt = '0; st_nxt = ST_NOITEM;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        hh_nxt = eh; ht_nxt = et; hc_nxt = ec; hs_nxt = es; hm_nxt = em;
        wb_nxt = 1'b1; widx_nxt = hi;
        state_nxt = S_DONE;
        if (cmd_r == CMD_CREATE) begin
          if (fhc_r != '0) begin
            widx_nxt = fhs_r[HW'(fhc_r - 1'b1)];
            fhc_nxt = fhc_r - 1'b1;
            st_nxt = ST_OK;
          end else if (32'(fresh_h_r) < HEAD_COUNT) begin
            widx_nxt = HW'(fresh_h_r);
            fresh_h_nxt = fresh_h_r + 1'b1;
            st_nxt = ST_OK;
          end else begin
            st_nxt = ST_NOFREE;
            wb_nxt = 1'b0;
          end
          newl_nxt = (st_nxt == ST_OK) ? 4'(widx_nxt) : 4'd0;
          hs_nxt = '0; hm_nxt = CUR_NONE;
        end else if (32'(h_r) >= HEAD_COUNT || cmd_r > CMD_FREE) begin
          wb_nxt = 1'b0; hs_nxt = '0;
        end else begin
          unique case (cmd_r) inside
            CMD_COUNT: st_nxt = ST_OK;
            CMD_FIRST, CMD_LAST: begin
              if (es == '0) begin
                hm_nxt = CUR_NONE;
              end else begin
                hm_nxt = CUR_NODE;
                hc_nxt = (cmd_r == CMD_FIRST) ? eh : et;
                im_ra = hc_nxt;
                state_nxt = S_ITEM;
              end
            end
            CMD_NEXT: begin
              if (es != '0) begin
                if (em == CUR_BEFORE) begin
                  hm_nxt = CUR_NODE; hc_nxt = eh; im_ra = eh; state_nxt = S_ITEM;
                end else if (em == CUR_NODE) begin
                  if (ec == et) hm_nxt = CUR_AFTER;
                  else begin
                    nx_ra = ec; state_nxt = S_STEP;
                  end
                end
              end
            end
            CMD_PREV: begin
              if (es != '0) begin
                if (em == CUR_AFTER) begin
                  hm_nxt = CUR_NODE; hc_nxt = et; im_ra = et; state_nxt = S_ITEM;
                end else if (em == CUR_NODE) begin
                  if (ec == eh) hm_nxt = CUR_BEFORE;
                  else begin
                    pv_ra = ec; state_nxt = S_STEP;
                  end
                end
              end
            end
            CMD_CURR: begin
              if (em == CUR_NODE && es != '0) begin
                im_ra = ec; state_nxt = S_ITEM;
              end
            end
            CMD_INS_AFTER, CMD_INS_BEFORE, CMD_APPEND, CMD_PREPEND: begin
              if (fcnt_r != '0) begin
                n_nxt = ftop_r; nx_ra = ftop_r; state_nxt = S_ALLOC;
              end else if (32'(fresh_n_r) < NODE_COUNT) begin
                n_nxt = NW'(fresh_n_r); fresh_n_nxt = fresh_n_r + 1'b1;
                state_nxt = S_LINK;
              end else begin
                st_nxt = ST_NOFREE;
              end
            end
            CMD_REMOVE, CMD_TRIM: begin
              if (es != '0 && (cmd_r == CMD_TRIM || em == CUR_NODE)) begin
                n_nxt = (cmd_r == CMD_TRIM) ? et : ec;
                im_ra = n_nxt; nx_ra = n_nxt; pv_ra = n_nxt;
                state_nxt = S_UNL;
              end
            end
            CMD_CONCAT: begin
              if (32'(h2_r) < HEAD_COUNT) begin
                st_nxt = ST_OK;
                if (h2_r != h_r) state_nxt = S_CAT;
              end
            end
            default: begin
              st_nxt = ST_OK;
              n_nxt = eh; k_nxt = es;
              if (es != '0) state_nxt = S_FREE_RD;
              else begin
                hm_nxt = CUR_NONE;
                fh_push = 1'b1; fh_push_val = hi;
              end
            end
          endcase
        end
      end
      S_ITEM: begin
        io_nxt = im_rd; st_nxt = ST_OK; state_nxt = S_DONE;
      end
      S_STEP: begin
        hc_nxt = (cmd_r == CMD_NEXT) ? nx_rd : pv_rd;
        im_ra = hc_nxt;
        state_nxt = S_ITEM;
      end
      S_ALLOC: begin
        ftop_nxt = nx_rd; fcnt_nxt = fcnt_r - 1'b1; state_nxt = S_LINK;
      end
      S_LINK: begin
        im_we = 1'b1;
        if (hs_r == '0) begin
          hh_nxt = n_r; ht_nxt = n_r;
          hs_nxt = hs_r + 1'b1; hm_nxt = CUR_NODE; hc_nxt = n_r; st_nxt = ST_OK;
          state_nxt = S_DONE;
        end else begin
          if (cmd_r == CMD_PREPEND || (where < 4'd2 && hm_r == CUR_BEFORE)) begin
            a_nxt = hh_r; after_nxt = 1'b0;
          end else if (where < 4'd2 && hm_r == CUR_NODE) begin
            a_nxt = hc_r; after_nxt = (cmd_r == CMD_INS_AFTER);
          end else begin
            a_nxt = ht_r; after_nxt = 1'b1;
          end
          nx_ra = a_nxt; pv_ra = a_nxt;
          state_nxt = S_LINK2;
        end
      end
      S_LINK2: begin
        xv = after_r ? nx_rd : pv_rd;
        x_nxt = xv;
        nx_we = 1'b1; pv_we = 1'b1; nx_wa = n_r; pv_wa = n_r;
        nx_wd = after_r ? xv : a_r;
        pv_wd = after_r ? a_r : xv;
        state_nxt = S_LINK3;
      end
      S_LINK3: begin
        if (after_r) begin
          nx_we = 1'b1; nx_wa = a_r; nx_wd = n_r;
          if (a_r == ht_r) ht_nxt = n_r;
          else begin
            pv_we = 1'b1; pv_wa = x_r; pv_wd = n_r;
          end
        end else begin
          pv_we = 1'b1; pv_wa = a_r; pv_wd = n_r;
          if (a_r == hh_r) hh_nxt = n_r;
          else begin
            nx_we = 1'b1; nx_wa = x_r; nx_wd = n_r;
          end
        end
        hs_nxt = hs_r + 1'b1; hm_nxt = CUR_NODE; hc_nxt = n_r; st_nxt = ST_OK;
        state_nxt = S_DONE;
      end
      S_UNL: begin
        io_nxt = im_rd; st_nxt = ST_OK;
        if (cmd_r == CMD_REMOVE) begin
          if (n_r == ht_r) hm_nxt = CUR_AFTER;
          else hc_nxt = nx_rd;
        end else begin
          if (hs_r == SW'(1)) hm_nxt = CUR_NONE;
          else begin
            hm_nxt = CUR_NODE; hc_nxt = pv_rd;
          end
        end
        if (n_r == hh_r) hh_nxt = nx_rd;
        else begin
          nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
        end
        if (n_r == ht_r) ht_nxt = pv_rd;
        else begin
          pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
        end
        hs_nxt = hs_r - 1'b1;
        state_nxt = S_REL;
      end
      S_REL: begin
        nx_we = 1'b1; nx_wa = n_r; nx_wd = ftop_r;
        ftop_nxt = n_r;
        if (32'(fcnt_r) < NODE_COUNT) fcnt_nxt = fcnt_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_CAT: begin
        if (bs != '0) begin
          if (hs_r == '0) begin
            hh_nxt = bh; ht_nxt = bt; hs_nxt = bs; hm_nxt = bm; hc_nxt = bc;
          end else begin
            nx_we = 1'b1; nx_wa = ht_r; nx_wd = bh;
            pv_we = 1'b1; pv_wa = bh; pv_wd = ht_r;
            ht_nxt = bt; hs_nxt = hs_r + bs;
          end
        end
        hw_en = 1'b1; hw_idx = h2i;
        hw_h = bh; hw_t = bt; hw_c = bc; hw_s = '0; hw_m = CUR_NONE;
        fh_push = 1'b1; fh_push_val = h2i;
        state_nxt = S_DONE;
      end
      S_FREE_RD: begin
        nx_ra = n_r; state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        nx_we = 1'b1; nx_wa = n_r; nx_wd = ftop_r;
        ftop_nxt = n_r;
        if (32'(fcnt_r) < NODE_COUNT) fcnt_nxt = fcnt_r + 1'b1;
        n_nxt = nx_rd; k_nxt = k_r - 1'b1;
        if (k_r == SW'(1)) begin
          hs_nxt = '0; hm_nxt = CUR_NONE;
          fh_push = 1'b1; fh_push_val = hi;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_DONE: begin
        hw_en = wb_r;
        out_valid_nxt = 1'b1;
        out_status_nxt = st_r;
        out_item_nxt = (st_r == ST_OK) ? 32'(io_r) : 32'd0;
        out_new_nxt = newl_r;
        out_cnt_nxt = 8'(hs_r);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fh_push && 32'(fhc_r) < HEAD_COUNT) fhc_nxt = fhc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fcnt_r <= '0; fresh_n_r <= '0; fresh_h_r <= '0; fhc_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HEAD_COUNT; i++) begin
        ls_r[i] <= '0;
        lm_r[i] <= CUR_NONE;
      end
    end else begin
      state_r <= state_nxt;
      fcnt_r <= fcnt_nxt; fresh_n_r <= fresh_n_nxt; fresh_h_r <= fresh_h_nxt;
      fhc_r <= fhc_nxt;
      out_valid_r <= out_valid_nxt;
      if (fh_push && 32'(fhc_r) < HEAD_COUNT) fhs_r[HW'(fhc_r)] <= fh_push_val;
      if (hw_en) begin
        lh_r[hw_idx] <= hw_h; lt_r[hw_idx] <= hw_t; lc_r[hw_idx] <= hw_c;
        ls_r[hw_idx] <= hw_s; lm_r[hw_idx] <= hw_m;
      end
    end
    cmd_r <= cmd_nxt; h_r <= h_nxt; h2_r <= h2_nxt; item_r <= item_nxt; io_r <= io_nxt;
    hh_r <= hh_nxt; ht_r <= ht_nxt; hc_r <= hc_nxt; hs_r <= hs_nxt; hm_r <= hm_nxt;
    st_r <= st_nxt; wb_r <= wb_nxt; after_r <= after_nxt; widx_r <= widx_nxt;
    newl_r <= newl_nxt; n_r <= n_nxt; a_r <= a_nxt; x_r <= x_nxt; k_r <= k_nxt;
    ftop_r <= ftop_nxt;
    out_status_r <= out_status_nxt; out_item_r <= out_item_nxt;
    out_new_r <= out_new_nxt; out_cnt_r <= out_cnt_nxt;
  end

endmodule
